/* hdl/gslg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel grid solver package
// Shared widths, command and register codes, and the grid memory request.
// ----------------------------------------------------------------------------
package gslg_pkg;

    localparam int MAX_SIZE  = 64;
    localparam int IDX_W     = 12;
    localparam int MEM_DEPTH = 1 << IDX_W;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 7;
    localparam int TOL_W     = 31;
    localparam int SWEEP_W   = 16;
    localparam int SUM_W     = DATA_W + 2;
    localparam int CHG_W     = DATA_W + 1;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_SOLVE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_LIMIT = 2'd2;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_mem_req;

endpackage

/* hdl/gslg_grid_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid node memory
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module gslg_grid_mem (
    input  logic                       i_clk,
    input  gslg_pkg::t_mem_req         i_req,
    output logic [gslg_pkg::DATA_W-1:0] o_rdata
);

    logic [gslg_pkg::DATA_W-1:0] r_mem [gslg_pkg::MEM_DEPTH];
    logic [gslg_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/gauss_seidel_laplace_grid_solver_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel five-point Laplace grid solver
// Holds a square grid in memory and relaxes its interior nodes in place.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Carries
//  in        input      i_in_valid / o_in_ready   command, node index, value
//  out       output     o_out_valid / i_out_ready result kind and report
//  cfg       input      i_cfg_wr_en               register index and data
//
// Node writes and reads are taken one per cycle while idle, unless a read
// waits on a stalled output; read data passes through the memory read
// register, then the output register. A solve sweeps the interior of an n
// by n grid (no nodes when n is below three); each interior node needs five
// reads through the single read port of the memory and a write of its new
// value. The grid memory is not cleared by reset. While a result is stalled,
// one further read is taken and held; after it every item waits, and a
// solve holds its report until the output register is free.
// ----------------------------------------------------------------------------
module gauss_seidel_laplace_grid_solver_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_command,
    input  logic [gslg_pkg::IDX_W-1:0]          i_node_index,
    input  logic signed [gslg_pkg::DATA_W-1:0]  i_node_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_result_kind,
    output logic signed [gslg_pkg::DATA_W-1:0]  o_read_value,
    output logic [gslg_pkg::SWEEP_W-1:0]        o_sweep_count,
    output logic [gslg_pkg::DATA_W-1:0]         o_final_change,
    output logic                                o_converged,
    input  logic                                i_cfg_wr_en,
    input  logic [gslg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gslg_pkg::TOL_W-1:0]          i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_UP,
        S_DN,
        S_LF,
        S_RT,
        S_CT,
        S_UPD,
        S_FOLD,
        S_CHK,
        S_REPORT
    } t_state;

    t_state                               r_state;
    logic [gslg_pkg::SIZE_W-1:0]          r_grid_size;
    logic [gslg_pkg::TOL_W-1:0]           r_tolerance;
    logic [gslg_pkg::SWEEP_W-1:0]         r_sweep_limit;
    logic [gslg_pkg::SWEEP_W-1:0]         r_sweeps;
    logic [gslg_pkg::CHG_W-1:0]           r_max;
    logic [gslg_pkg::CHG_W-1:0]           r_diff;
    logic                                 r_diff_vld;
    logic signed [gslg_pkg::SUM_W-1:0]    r_sum;
    logic [gslg_pkg::IDX_W-1:0]           r_at;
    logic [gslg_pkg::SIZE_W-1:0]          r_row;
    logic [gslg_pkg::SIZE_W-1:0]          r_col;
    logic                                 r_rd_pend;
    logic                                 r_ovalid;
    logic                                 r_okind;
    logic [gslg_pkg::DATA_W-1:0]          r_oread;
    logic [gslg_pkg::SWEEP_W-1:0]         r_osweeps;
    logic [gslg_pkg::DATA_W-1:0]          r_ofinal;
    logic                                 r_oconv;

    gslg_pkg::t_mem_req                   w_req;
    logic [gslg_pkg::DATA_W-1:0]          w_rdata;
    gslg_pkg::t_cmd                       w_cmd;
    logic                                 w_accept;
    logic                                 w_out_free;
    logic [gslg_pkg::SIZE_W-1:0]          w_n;
    logic [gslg_pkg::SIZE_W-1:0]          w_last;
    logic [gslg_pkg::IDX_W-1:0]           w_n_idx;
    logic [gslg_pkg::SWEEP_W-1:0]         w_limit;
    logic [gslg_pkg::SWEEP_W-1:0]         n_sweeps;
    logic signed [gslg_pkg::SUM_W-1:0]    w_rdata_ext;
    logic [gslg_pkg::DATA_W-1:0]          n_value;
    logic signed [gslg_pkg::CHG_W-1:0]    w_up_diff;
    logic signed [gslg_pkg::CHG_W-1:0]    w_dn_diff;
    logic                                 w_conv;

    assign w_cmd      = gslg_pkg::t_cmd'(i_command);
    assign w_out_free = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && (!r_rd_pend || w_out_free);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_n     = (r_grid_size > gslg_pkg::SIZE_W'(gslg_pkg::MAX_SIZE))
                   ? gslg_pkg::SIZE_W'(gslg_pkg::MAX_SIZE) : r_grid_size;
    assign w_last  = w_n - gslg_pkg::SIZE_W'(2);
    assign w_n_idx = gslg_pkg::IDX_W'(w_n);
    assign w_limit = (r_sweep_limit == '0) ? gslg_pkg::SWEEP_W'(1) : r_sweep_limit;
    assign n_sweeps = r_sweeps + gslg_pkg::SWEEP_W'(1);
    assign w_conv  = r_max <= gslg_pkg::CHG_W'(r_tolerance);

    assign w_rdata_ext = gslg_pkg::SUM_W'(signed'(w_rdata));
    assign n_value     = r_sum[gslg_pkg::SUM_W-1:2];
    assign w_up_diff   = gslg_pkg::CHG_W'(signed'(n_value))
                       - gslg_pkg::CHG_W'(signed'(w_rdata));
    assign w_dn_diff   = gslg_pkg::CHG_W'(signed'(w_rdata))
                       - gslg_pkg::CHG_W'(signed'(n_value));

    always_comb begin
        w_req.we    = 1'b0;
        w_req.waddr = i_node_index;
        w_req.wdata = i_node_value;
        w_req.re    = 1'b0;
        w_req.raddr = i_node_index;
        unique case (r_state)
            S_IDLE: begin
                w_req.we = w_accept && (w_cmd == gslg_pkg::CMD_WRITE);
                w_req.re = w_accept && (w_cmd == gslg_pkg::CMD_READ);
            end
            S_UP: begin
                w_req.re    = 1'b1;
                w_req.raddr = r_at - w_n_idx;
            end
            S_DN: begin
                w_req.re    = 1'b1;
                w_req.raddr = r_at + w_n_idx;
            end
            S_LF: begin
                w_req.re    = 1'b1;
                w_req.raddr = r_at - gslg_pkg::IDX_W'(1);
            end
            S_RT: begin
                w_req.re    = 1'b1;
                w_req.raddr = r_at + gslg_pkg::IDX_W'(1);
            end
            S_CT: begin
                w_req.re    = 1'b1;
                w_req.raddr = r_at;
            end
            S_UPD: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_at;
                w_req.wdata = n_value;
            end
            default: begin
            end
        endcase
    end

    gslg_grid_mem u_grid_mem (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_grid_size   <= gslg_pkg::SIZE_W'(64);
            r_tolerance   <= gslg_pkg::TOL_W'(66);
            r_sweep_limit <= gslg_pkg::SWEEP_W'(65535);
            r_sweeps      <= '0;
            r_max         <= '0;
            r_diff_vld    <= 1'b0;
            r_rd_pend     <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    gslg_pkg::REG_GRID_SIZE:   r_grid_size <= i_cfg_wdata[gslg_pkg::SIZE_W-1:0];
                    gslg_pkg::REG_TOLERANCE:   r_tolerance <= i_cfg_wdata;
                    gslg_pkg::REG_SWEEP_LIMIT: begin
                        r_sweep_limit <= i_cfg_wdata[gslg_pkg::SWEEP_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            r_diff_vld <= 1'b0;
            if (r_diff_vld && (r_diff > r_max)) begin
                r_max <= r_diff;
            end

            if (r_rd_pend && w_out_free) begin
                r_ovalid  <= 1'b1;
                r_okind   <= 1'b0;
                r_oread   <= w_rdata;
                r_osweeps <= '0;
                r_ofinal  <= '0;
                r_oconv   <= 1'b0;
            end else if ((r_state == S_REPORT) && w_out_free) begin
                r_ovalid  <= 1'b1;
                r_okind   <= 1'b1;
                r_oread   <= '0;
                r_osweeps <= r_sweeps;
                r_ofinal  <= r_max[gslg_pkg::DATA_W-1:0];
                r_oconv   <= w_conv;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            if (w_accept && (w_cmd == gslg_pkg::CMD_READ)) begin
                r_rd_pend <= 1'b1;
            end else if (w_out_free) begin
                r_rd_pend <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (w_cmd == gslg_pkg::CMD_SOLVE)) begin
                        r_sweeps <= '0;
                        r_state  <= S_START;
                    end
                end
                S_START: begin
                    r_max <= '0;
                    r_at  <= w_n_idx + gslg_pkg::IDX_W'(1);
                    r_row <= gslg_pkg::SIZE_W'(1);
                    r_col <= gslg_pkg::SIZE_W'(1);
                    if (w_n < gslg_pkg::SIZE_W'(3)) begin
                        r_state <= S_FOLD;
                    end else begin
                        r_state <= S_UP;
                    end
                end
                S_UP: r_state <= S_DN;
                S_DN: begin
                    r_sum   <= w_rdata_ext;
                    r_state <= S_LF;
                end
                S_LF: begin
                    r_sum   <= r_sum + w_rdata_ext;
                    r_state <= S_RT;
                end
                S_RT: begin
                    r_sum   <= r_sum + w_rdata_ext;
                    r_state <= S_CT;
                end
                S_CT: begin
                    r_sum   <= r_sum + w_rdata_ext;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_diff     <= w_up_diff[gslg_pkg::CHG_W-1] ? w_dn_diff : w_up_diff;
                    r_diff_vld <= 1'b1;
                    if (r_col == w_last) begin
                        if (r_row == w_last) begin
                            r_state <= S_FOLD;
                        end else begin
                            r_row   <= r_row + gslg_pkg::SIZE_W'(1);
                            r_col   <= gslg_pkg::SIZE_W'(1);
                            r_at    <= r_at + gslg_pkg::IDX_W'(3);
                            r_state <= S_UP;
                        end
                    end else begin
                        r_col   <= r_col + gslg_pkg::SIZE_W'(1);
                        r_at    <= r_at + gslg_pkg::IDX_W'(1);
                        r_state <= S_UP;
                    end
                end
                S_FOLD: r_state <= S_CHK;
                S_CHK: begin
                    r_sweeps <= n_sweeps;
                    if (!w_conv && (n_sweeps < w_limit)) begin
                        r_state <= S_START;
                    end else begin
                        r_state <= S_REPORT;
                    end
                end
                S_REPORT: begin
                    if (!r_rd_pend && w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_result_kind  = r_okind;
    assign o_read_value   = r_oread;
    assign o_sweep_count  = r_osweeps;
    assign o_final_change = r_ofinal;
    assign o_converged    = r_oconv;

endmodule

/* dv/gslg_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel grid solver result checker
// Follows register writes and accepted items to keep its own copy of the grid
// and registers, works out the read data and solve report that each item
// should give, and compares every accepted result with the oldest one due.
// ----------------------------------------------------------------------------
module gslg_result_checker
    import gslg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [1:0]               i_command,
    input  logic [IDX_W-1:0]         i_node_index,
    input  logic signed [DATA_W-1:0] i_node_value,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_result_kind,
    input  logic signed [DATA_W-1:0] i_read_value,
    input  logic [SWEEP_W-1:0]       i_sweep_count,
    input  logic [DATA_W-1:0]        i_final_change,
    input  logic                     i_converged,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [TOL_W-1:0]         i_cfg_wdata,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic               kind;
        logic [DATA_W-1:0]  value;
        logic [SWEEP_W-1:0] sweeps;
        logic [DATA_W-1:0]  change;
        logic               conv;
    } t_result;

    logic [DATA_W-1:0]  grid_nodes [MEM_DEPTH];
    logic [SIZE_W-1:0]  grid_size;
    logic [TOL_W-1:0]   tolerance;
    logic [SWEEP_W-1:0] sweep_limit;
    t_result            reports_due [$];
    int                 mismatches;

    initial begin
        mismatches   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        foreach (grid_nodes[i]) grid_nodes[i] = '0;
    end

    // One in-place sweep over the interior; returns the largest absolute change.
    function automatic logic [CHG_W-1:0] relax_grid(input int n);
        t_sum              total;
        t_sum              averaged;
        t_sum              delta;
        logic [CHG_W-1:0]  worst;
        int                at;
        worst = '0;
        for (int r = 1; r + 1 < n; r++) begin
            for (int c = 1; c + 1 < n; c++) begin
                at = r * n + c;
                total = t_sum'($signed(grid_nodes[at - n])) + t_sum'($signed(grid_nodes[at + n]))
                      + t_sum'($signed(grid_nodes[at - 1])) + t_sum'($signed(grid_nodes[at + 1]));
                averaged = total >>> 2;
                delta = averaged - t_sum'($signed(grid_nodes[at]));
                if (delta < 0) begin
                    delta = -delta;
                end
                grid_nodes[at] = averaged[DATA_W-1:0];
                if (delta[CHG_W-1:0] > worst) begin
                    worst = delta[CHG_W-1:0];
                end
            end
        end
        return worst;
    endfunction

    function automatic t_result solve_grid();
        int               n;
        int               limit;
        int               sweeps;
        logic [CHG_W-1:0] worst;
        t_result          report;
        n      = (grid_size > MAX_SIZE) ? MAX_SIZE : int'(grid_size);
        limit  = (sweep_limit == '0) ? 1 : int'(sweep_limit);
        sweeps = 0;
        do begin
            worst = relax_grid(n);
            sweeps++;
        end while (worst > CHG_W'(tolerance) && sweeps < limit);
        report        = '0;
        report.kind   = 1'b1;
        report.sweeps = sweeps[SWEEP_W-1:0];
        report.change = worst[DATA_W-1:0];
        report.conv   = (worst <= CHG_W'(tolerance));
        return report;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            grid_size   = 7'd64;
            tolerance   = 31'd66;
            sweep_limit = 16'hFFFF;
            reports_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_GRID_SIZE:   grid_size   = i_cfg_wdata[SIZE_W-1:0];
                    REG_TOLERANCE:   tolerance   = i_cfg_wdata;
                    REG_SWEEP_LIMIT: sweep_limit = i_cfg_wdata[SWEEP_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_command)
                    CMD_WRITE: grid_nodes[i_node_index] = i_node_value;
                    CMD_READ: begin
                        want       = '0;
                        want.value = grid_nodes[i_node_index];
                        reports_due.push_back(want);
                    end
                    CMD_SOLVE: reports_due.push_back(solve_grid());
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                seen.kind   = i_result_kind;
                seen.value  = i_read_value;
                seen.sweeps = i_sweep_count;
                seen.change = i_final_change;
                seen.conv   = i_converged;
                if (reports_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with none due: kind %0b value %h sweeps %0d change %h conv %0b",
                                 $realtime, seen.kind, seen.value, seen.sweeps, seen.change,
                                 seen.conv);
                    end
                end else begin
                    want = reports_due.pop_front();
                    if (seen.kind !== want.kind || seen.value !== want.value
                            || seen.sweeps !== want.sweeps || seen.change !== want.change
                            || seen.conv !== want.conv) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch: expected kind %0b value %h sweeps %0d change %h conv %0b",
                                     $realtime, want.kind, want.value, want.sweeps, want.change,
                                     want.conv);
                            $display("%0t:                  got      kind %0b value %h sweeps %0d change %h conv %0b",
                                     $realtime, seen.kind, seen.value, seen.sweeps, seen.change,
                                     seen.conv);
                        end
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= reports_due.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gauss-Seidel grid solver testbench
// Drives directed corner cases, a load of a block of low nodes and of the top
// of the grid memory, and then random phases of node writes, reads and
// solves under varied registers, with bursty input and a stalling receiver.
// The result checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import gslg_pkg::*;

    localparam int STALL_LIMIT   = 250000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 140;
    localparam int SOLVE_BUDGET  = 2500;
    localparam int LOW_NODES     = 128;
    localparam int HIGH_NODES    = 16;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [DATA_W-1:0] CORNER_VALUES [9] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
        32'hFFFF_FFFF, 32'h1234_5678, 32'h7FFF_FFFF,
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [1:0]               i_command;
    logic [IDX_W-1:0]         i_node_index;
    logic signed [DATA_W-1:0] i_node_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic                     o_result_kind;
    logic signed [DATA_W-1:0] o_read_value;
    logic [SWEEP_W-1:0]       o_sweep_count;
    logic [DATA_W-1:0]        o_final_change;
    logic                     o_converged;
    logic                     i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [TOL_W-1:0]         i_cfg_wdata;

    int fail_count;
    int results_pending;
    int burst_left;
    int quiet_cycles;

    gauss_seidel_laplace_grid_solver_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_node_index   (i_node_index),
        .i_node_value   (i_node_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_read_value   (o_read_value),
        .o_sweep_count  (o_sweep_count),
        .o_final_change (o_final_change),
        .o_converged    (o_converged),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    gslg_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_node_index   (i_node_index),
        .i_node_value   (i_node_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_result_kind  (o_result_kind),
        .i_read_value   (o_read_value),
        .i_sweep_count  (o_sweep_count),
        .i_final_change (o_final_change),
        .i_converged    (o_converged),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : receiver
        int mode;
        int left;
        mode        = 0;
        left        = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(8, 300);
            end
            left--;
            case (mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2: i_out_ready <= ($urandom_range(0, 5) == 0);
                default: i_out_ready <= ~i_out_ready;
            endcase
        end
    end

    function automatic logic [DATA_W-1:0] node_value(input int mode);
        case (mode)
            0: return $urandom;
            1: return DATA_W'($urandom_range(0, 1 << 20)) - DATA_W'(1 << 19);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // The low nodes and the top of the memory are all written early on.
    function automatic int pick_index(input int span);
        if ($urandom_range(0, 3) == 0) begin
            return MEM_DEPTH - 1 - int'($urandom_range(0, HIGH_NODES - 1));
        end
        return $urandom_range(0, span - 1);
    endfunction

    // Called and left at a falling edge; valid stays high across a burst.
    task automatic send_item(input logic [1:0] cmd, input int idx,
                             input logic [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
            case ($urandom_range(0, 3))
                0: gap = 0;
                3: gap = $urandom_range(4, 20);
                default: gap = $urandom_range(1, 3);
            endcase
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_node_index <= idx[IDX_W-1:0];
        i_node_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_regs(input int size, input logic [TOL_W-1:0] tol,
                                input logic [SWEEP_W-1:0] limit);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_GRID_SIZE;
        i_cfg_wdata <= TOL_W'(size);
        @(negedge i_clk);
        i_cfg_index <= REG_TOLERANCE;
        i_cfg_wdata <= tol;
        @(negedge i_clk);
        i_cfg_index <= REG_SWEEP_LIMIT;
        i_cfg_wdata <= TOL_W'(limit);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic fill_grid(input int span, input int mode);
        for (int i = 0; i < span; i++) begin
            send_item(CMD_WRITE, i, node_value(mode));
        end
    endtask

    task automatic run_phase();
        int                 size;
        int                 span;
        int                 cost;
        int                 cap;
        int                 act;
        int                 count;
        int                 mode;
        int                 base;
        logic [TOL_W-1:0]   tol;
        logic [SWEEP_W-1:0] limit;
        wait_results();
        size = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
        span = (size == 0) ? 1 : size * size;
        case ($urandom_range(0, 7))
            0: tol = '0;
            1: tol = '1;
            2: tol = TOL_W'($urandom);
            default: tol = TOL_W'($urandom_range(0, 4096));
        endcase
        if (size < 3) begin
            limit = SWEEP_W'($urandom_range(0, 65535));
        end else if (size == 3) begin
            limit = ($urandom_range(0, 1) == 1) ? 16'hFFFF : SWEEP_W'($urandom_range(0, 8));
        end else begin
            cost  = 6 * (size - 2) * (size - 2) + 3;
            cap   = (SOLVE_BUDGET / cost < 1) ? 1 : SOLVE_BUDGET / cost;
            limit = ($urandom_range(0, 7) == 0) ? '0 : SWEEP_W'($urandom_range(1, cap));
        end
        program_regs(size, tol, limit);
        mode = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 1;
        fill_grid(size * size, mode);
        count = size * size;
        while (count < PHASE_ITEMS) begin
            act = $urandom_range(0, 99);
            if (act < 40) begin
                send_item(CMD_WRITE, pick_index(span), node_value(mode));
                count++;
            end else if (act < 72) begin
                send_item(CMD_READ, pick_index(span), $urandom);
                count++;
            end else if (act < 78) begin
                send_item(CMD_SOLVE, $urandom_range(0, MEM_DEPTH - 1), $urandom);
                count++;
            end else if (act < 82) begin
                send_item(CMD_NONE, $urandom_range(0, MEM_DEPTH - 1), $urandom);
            end else if (act < 84) begin
                wait_results();
            end else if (act < 94) begin
                if (span <= 36) begin
                    fill_grid(size * size, $urandom_range(0, 2));
                    count += size * size;
                end else begin
                    for (int k = 0; k < size; k++) begin
                        send_item(CMD_WRITE, $urandom_range(0, span - 1), node_value(mode));
                    end
                    count += size;
                end
                send_item(CMD_SOLVE, $urandom_range(0, MEM_DEPTH - 1), $urandom);
                count++;
            end else begin
                base = pick_index(span);
                for (int k = 0; k <= size; k++) begin
                    send_item(CMD_READ, (base + k) % MEM_DEPTH, $urandom);
                end
                count += size + 1;
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_WRITE;
        i_node_index = '0;
        i_node_value = '0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = REG_GRID_SIZE;
        i_cfg_wdata  = '0;
        burst_left   = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A single interior node settles in two sweeps, even with zero tolerance.
        program_regs(3, '0, 16'hFFFF);
        for (int i = 0; i < 9; i++) begin
            send_item(CMD_WRITE, i, CORNER_VALUES[i]);
        end
        send_item(CMD_SOLVE, 0, '0);
        send_item(CMD_READ, 4, '0);
        send_item(CMD_READ, 1, '1);
        send_item(CMD_NONE, MEM_DEPTH - 1, '1);
        send_item(CMD_WRITE, MEM_DEPTH - 1, 32'h8000_0001);
        send_item(CMD_READ, MEM_DEPTH - 1, '0);
        wait_results();
        program_regs(1, '0, '0);
        send_item(CMD_SOLVE, 0, '0);
        wait_results();
        program_regs(0, '1, 16'd1);
        send_item(CMD_SOLVE, 0, '0);
        wait_results();
        program_regs(3, '0, '0);
        send_item(CMD_WRITE, 4, 32'h7FFF_FFFF);
        send_item(CMD_SOLVE, 0, '0);
        send_item(CMD_READ, 4, '0);

        // Load a block of low nodes and the top of the memory, which makes
        // every later read and solve operand a written node.
        wait_results();
        program_regs(11, '0, 16'd1);
        fill_grid(LOW_NODES, 0);
        for (int i = MEM_DEPTH - HIGH_NODES; i < MEM_DEPTH; i++) begin
            send_item(CMD_WRITE, i, node_value(0));
        end
        send_item(CMD_SOLVE, 0, '0);
        for (int i = 0; i < 8; i++) begin
            send_item(CMD_READ, pick_index(LOW_NODES), '0);
        end
        wait_results();
        program_regs(11, '1, 16'd2);
        send_item(CMD_SOLVE, 0, '0);
        send_item(CMD_READ, 12, '0);

        for (int p = 0; p < PHASES; p++) begin
            run_phase();
        end
        wait_results();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
